@@ rtl/clipped_spiral_grid_order_unit_assert.svh @@
// Assertion shorthands for the spiral order unit.
// Each macro expects signals named clock and reset in the including module.
`ifndef CLIPPED_SPIRAL_GRID_ORDER_UNIT_ASSERT_SVH
`define CLIPPED_SPIRAL_GRID_ORDER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CSGO_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CSGO_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/csgo_pkg.sv @@
package csgo_pkg;

   // Grid limits and port widths.
   localparam logic [3:0] MAX_ROWS   = 4'd8;
   localparam logic [3:0] MAX_COLS   = 4'd8;
   localparam int         REQ_DATA_W = 8;
   localparam int         RSP_DATA_W = 24;
   localparam int         CSR_IDX_W  = 2;
   localparam int         CSR_DATA_W = 4;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_ROWS  = 2'd0,
      CSR_GRID_COLS  = 2'd1,
      CSR_CENTER_ROW = 2'd2,
      CSR_CENTER_COL = 2'd3
   } csr_index_type;

   // Sides of one ring: a single step up, then right, down, left and up.
   typedef enum logic [2:0] {
      PH_ENTRY = 3'd0,
      PH_RIGHT = 3'd1,
      PH_DOWN  = 3'd2,
      PH_LEFT  = 3'd3,
      PH_UP    = 3'd4
   } phase_type;

   // Program counter of the sequencer.
   typedef enum logic [1:0] {
      PC_IDLE   = 2'd0,
      PC_CENTRE = 2'd1,
      PC_WALK   = 2'd2
   } pc_type;

   // Jump conditions.
   typedef enum logic {
      COND_START = 1'b0,
      COND_DONE  = 1'b1
   } cond_type;

   // One control word of the program.
   typedef struct packed {
      logic     take_item;
      logic     emit_centre;
      logic     walk;
      cond_type cond;
      pc_type   on_true;
      pc_type   on_false;
   } uword_type;

   typedef struct packed {
      logic signed [4:0] row;
      logic signed [4:0] col;
   } delta_type;

   // Program store: waits for a start word, emits the centre, then walks
   // one spiral position per step until the last cell has been sent.
   function automatic uword_type ucode(input pc_type pc);
      uword_type w;
      unique case (pc)
         PC_IDLE:   w = '{1'b1, 1'b0, 1'b0, COND_START, PC_CENTRE, PC_IDLE};
         PC_CENTRE: w = '{1'b0, 1'b1, 1'b0, COND_DONE,  PC_IDLE,   PC_WALK};
         PC_WALK:   w = '{1'b0, 1'b0, 1'b1, COND_DONE,  PC_IDLE,   PC_WALK};
         default:   w = '{1'b1, 1'b0, 1'b0, COND_START, PC_CENTRE, PC_IDLE};
      endcase
      return w;
   endfunction

   // Move of one step on each side of a ring.
   function automatic delta_type phase_delta(input phase_type ph);
      delta_type d;
      unique case (ph)
         PH_ENTRY: d = '{-5'sd1, 5'sd0};
         PH_RIGHT: d = '{5'sd0, 5'sd1};
         PH_DOWN:  d = '{5'sd1, 5'sd0};
         PH_LEFT:  d = '{5'sd0, -5'sd1};
         PH_UP:    d = '{-5'sd1, 5'sd0};
         default:  d = '{5'sd0, 5'sd0};
      endcase
      return d;
   endfunction

   // Size register as used: zero counts as one, large values saturate.
   function automatic logic [3:0] clamp_size(input logic [3:0] v, input logic [3:0] maxv);
      logic [3:0] r;
      if (v == 4'd0) begin
         r = 4'd1;
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

@@ rtl/clipped_spiral_grid_order_unit.sv @@
// Channel  Direction  Handshake              Contents
// req      in         req_tvalid/req_tready  start word: start_req in bit 0
// rsp      out        rsp_tvalid/rsp_tready  one grid cell per word, rsp_tlast on the final cell
// csr      in         csr_valid/csr_ready    register index and write data
//
// A start word with start_req high is taken, the centre is sent next, and then
// the walker visits one spiral position per cycle while the output register does
// not stall it, in or out of the grid; the longest run is an 8 by 8 grid centred
// on its bottom-right corner.
// A start word with start_req low is consumed and produces nothing.
// Reset is synchronous and active high; it restores the register defaults.
// A full output register with rsp_tready low holds the sequencer on the cell.
`include "clipped_spiral_grid_order_unit_assert.svh"

module clipped_spiral_grid_order_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [csgo_pkg::REQ_DATA_W-1:0]   req_tdata,   // [0] start_req, rest zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [csgo_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [2:0] cell_row, [5:3] cell_col,
                                                          // [11:6] slot_index, [17:12] rank
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [csgo_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [csgo_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import csgo_pkg::*;

   // Configuration registers.
   logic [3:0] grid_rows_ff, grid_cols_ff;
   logic [2:0] center_row_ff, center_col_ff;

   // Sequencer and walker state.
   pc_type            pc_ff, pc_in;
   logic [3:0]        eff_rows_ff, eff_rows_in, eff_cols_ff, eff_cols_in;
   logic [6:0]        total_ff, total_in, count_ff, count_in;
   logic signed [4:0] row_ff, row_in, col_ff, col_in;
   logic [3:0]        level_ff, level_in;
   phase_type         phase_ff, phase_in;
   logic [4:0]        step_ff, step_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [5:0] rsp_slot_ff, rsp_slot_in, rsp_rank_ff, rsp_rank_in;
   logic       rsp_last_ff, rsp_last_in;

   uword_type         uw;
   delta_type         dlt;
   logic signed [4:0] next_row, next_col;
   logic              in_grid, accept, start, out_free, emit, stall, is_last, cond_true;
   logic [2:0]        emit_row, emit_col;
   logic [6:0]        row_times_cols;
   logic [4:0]        side_len, step_next;
   logic [3:0]        clamp_rows, clamp_cols;
   logic [2:0]        max_row, max_col;

   assign csr_ready = 1'b1;

   // Register writes; an index outside the list cannot occur with this index width.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff  <= 4'd8;
         grid_cols_ff  <= 4'd8;
         center_row_ff <= 3'd3;
         center_col_ff <= 3'd3;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_ROWS:  grid_rows_ff  <= csr_wdata;
            CSR_GRID_COLS:  grid_cols_ff  <= csr_wdata;
            CSR_CENTER_ROW: center_row_ff <= csr_wdata[2:0];
            CSR_CENTER_COL: center_col_ff <= csr_wdata[2:0];
         endcase
      end
   end

   // Control word fetch and input handshake.
   assign uw         = ucode(pc_ff);
   assign req_tready = uw.take_item;
   assign accept     = req_tvalid & req_tready;
   assign start      = accept & req_tdata[0];
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // Sizes and centre as used for a new run.
   assign clamp_rows = clamp_size(grid_rows_ff, MAX_ROWS);
   assign clamp_cols = clamp_size(grid_cols_ff, MAX_COLS);
   assign max_row    = 3'(clamp_rows - 4'd1);
   assign max_col    = 3'(clamp_cols - 4'd1);

   // Walker: candidate position and its place in the grid.
   assign dlt      = phase_delta(phase_ff);
   assign next_row = row_ff + dlt.row;
   assign next_col = col_ff + dlt.col;
   assign in_grid  = (next_row >= 5'sd0) && (next_row < $signed({1'b0, eff_rows_ff})) &&
                     (next_col >= 5'sd0) && (next_col < $signed({1'b0, eff_cols_ff}));

   // Side length: one step on entry, 2k-1 to the right, 2k on the others.
   always_comb begin
      case (phase_ff)
         PH_ENTRY: side_len = 5'd1;
         PH_RIGHT: side_len = {level_ff, 1'b0} - 5'd1;
         default:  side_len = {level_ff, 1'b0};
      endcase
   end
   assign step_next = step_ff + 5'd1;

   // Emission of a cell and the flow control around it.
   assign emit           = uw.emit_centre | (uw.walk & in_grid);
   assign emit_row       = uw.emit_centre ? row_ff[2:0] : next_row[2:0];
   assign emit_col       = uw.emit_centre ? col_ff[2:0] : next_col[2:0];
   assign stall          = emit & ~out_free;
   assign is_last        = emit & ((count_ff + 7'd1) == total_ff);
   assign row_times_cols = {4'd0, emit_row} * {3'd0, eff_cols_ff};

   // Jump condition of the current word.
   always_comb begin
      unique case (uw.cond)
         COND_START: cond_true = start;
         COND_DONE:  cond_true = is_last & ~stall;
         default:    cond_true = 1'b0;
      endcase
   end

   // Next program counter.
   always_comb begin
      if (stall) begin
         pc_in = pc_ff;
      end else if (cond_true) begin
         pc_in = uw.on_true;
      end else begin
         pc_in = uw.on_false;
      end
   end

   // Datapath next values.
   always_comb begin
      eff_rows_in  = eff_rows_ff;
      eff_cols_in  = eff_cols_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      level_in     = level_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_rank_in  = rsp_rank_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      // A new run latches sizes and puts the walker on the clamped centre.
      if (start) begin
         eff_rows_in = clamp_rows;
         eff_cols_in = clamp_cols;
         total_in    = 7'({4'd0, clamp_rows} * {4'd0, clamp_cols});
         count_in    = 7'd0;
         row_in      = $signed({2'b00, (center_row_ff > max_row) ? max_row : center_row_ff});
         col_in      = $signed({2'b00, (center_col_ff > max_col) ? max_col : center_col_ff});
      end

      // After the centre the walker begins ring one.
      if (uw.emit_centre && !stall) begin
         level_in = 4'd1;
         phase_in = PH_ENTRY;
         step_in  = 5'd0;
      end

      // One spiral position a cycle unless stalled, turning at the end of each side.
      if (uw.walk && !stall) begin
         row_in = next_row;
         col_in = next_col;
         if (step_next == side_len) begin
            step_in = 5'd0;
            if (phase_ff == PH_UP) begin
               phase_in = PH_ENTRY;
               level_in = level_ff + 4'd1;
            end else begin
               phase_in = phase_type'(phase_ff + 3'd1);
            end
         end else begin
            step_in = step_next;
         end
      end

      // Load the output register with the visited cell.
      if (emit && !stall) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = emit_row;
         rsp_col_in   = emit_col;
         rsp_slot_in  = row_times_cols[5:0] + {3'd0, emit_col};
         rsp_rank_in  = count_ff[5:0];
         rsp_last_in  = is_last;
         count_in     = count_ff + 7'd1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and walker registers.
   always_ff @(posedge clock) begin
      eff_rows_ff <= eff_rows_in;
      eff_cols_ff <= eff_cols_in;
      total_ff    <= total_in;
      count_ff    <= count_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      level_ff    <= level_in;
      phase_ff    <= phase_in;
      step_ff     <= step_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_rank_ff <= rsp_rank_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'd0, rsp_rank_ff, rsp_slot_ff, rsp_col_ff, rsp_row_ff};

   // Checks on the sequencer and the walker.
   `CSGO_ASSERT_SAME(a_count_below_total, pc_ff != PC_IDLE, count_ff < total_ff, "count overran total")
   `CSGO_ASSERT_NEXT(a_row_in_grid, emit && !stall, 4'(rsp_row_ff) < eff_rows_ff, "row outside grid")
   `CSGO_ASSERT_NEXT(a_last_ends_run, emit && !stall && is_last, pc_ff == PC_IDLE, "run did not end")
   `CSGO_ASSERT_NEXT(a_run_continues, emit && !stall && !is_last, pc_ff == PC_WALK, "run ended early")

endmodule

@@ bench/clipped_spiral_grid_order_unit_test.sv @@
module clipped_spiral_grid_order_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import csgo_pkg::*;

   // One grid cell as it should appear on the result stream.
   typedef struct packed {
      logic [2:0] row;
      logic [2:0] col;
      logic [5:0] slot;
      logic [5:0] rank;
      logic       last;
   } grid_word_type;

   // Keeps its own copy of the registers, works out the spiral for every
   // start word taken by the block and checks the cells that come back.
   class spiral_order_tracker;
      logic [3:0] rows_reg = 4'd8;
      logic [3:0] cols_reg = 4'd8;
      logic [2:0] crow_reg = 3'd3;
      logic [2:0] ccol_reg = 3'd3;
      grid_word_type cells_due[$];
      int         errors = 0;
      int         run_rows, run_cols, run_total, run_made;

      function void set_register(csr_index_type idx, logic [3:0] value);
         case (idx)
            CSR_GRID_ROWS:  rows_reg = value;
            CSR_GRID_COLS:  cols_reg = value;
            CSR_CENTER_ROW: crow_reg = value[2:0];
            CSR_CENTER_COL: ccol_reg = value[2:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return cells_due.size();
      endfunction

      // Queue a cell if it lies in the grid and the run is not yet complete.
      function void note_cell(int r, int c);
         grid_word_type due;
         if (run_made >= run_total) return;
         if (r < 0 || r >= run_rows || c < 0 || c >= run_cols) return;
         due.row  = r[2:0];
         due.col  = c[2:0];
         due.slot = 6'(r * run_cols + c);
         due.rank = 6'(run_made);
         run_made++;
         due.last = (run_made == run_total);
         cells_due.insert(cells_due.size(), due);
      endfunction

      // A start word with the start flag low leaves everything as it is.
      function void note_start(logic [REQ_DATA_W-1:0] word);
         int        r, c, lvl, len, dr, dc;
         phase_type ph;
         if (!word[0]) return;
         // Sizes of zero count as one, oversized values saturate.
         run_rows  = (rows_reg == 4'd0) ? 1 : (rows_reg > MAX_ROWS) ? int'(MAX_ROWS)
                                                                     : int'(rows_reg);
         run_cols  = (cols_reg == 4'd0) ? 1 : (cols_reg > MAX_COLS) ? int'(MAX_COLS)
                                                                     : int'(cols_reg);
         run_total = run_rows * run_cols;
         run_made  = 0;
         // The centre is pulled back into the grid when it lies outside.
         r = (int'(crow_reg) > run_rows - 1) ? run_rows - 1 : int'(crow_reg);
         c = (int'(ccol_reg) > run_cols - 1) ? run_cols - 1 : int'(ccol_reg);
         note_cell(r, c);
         for (lvl = 1; run_made < run_total && lvl <= 16; lvl++) begin
            for (int p = 0; p < 5 && run_made < run_total; p++) begin
               ph = phase_type'(p);
               case (ph)
                  PH_ENTRY: len = 1;
                  PH_RIGHT: len = 2 * lvl - 1;
                  default:  len = 2 * lvl;
               endcase
               case (ph)
                  PH_RIGHT: begin dr = 0;  dc = 1;  end
                  PH_DOWN:  begin dr = 1;  dc = 0;  end
                  PH_LEFT:  begin dr = 0;  dc = -1; end
                  default:  begin dr = -1; dc = 0;  end
               endcase
               for (int s = 0; s < len && run_made < run_total; s++) begin
                  r += dr;
                  c += dc;
                  note_cell(r, c);
               end
            end
         end
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      // Compare one result word with the oldest cell still owed.
      task check_cell(logic [RSP_DATA_W-1:0] data, logic tl);
         grid_word_type exp;
         if (cells_due.size() == 0) begin
            report($sformatf("cell word %h arrived with nothing owed", data));
            return;
         end
         exp = cells_due.pop_front();
         if (data[2:0] != exp.row)
            report($sformatf("rank %0d: row %0d, wanted %0d", exp.rank, data[2:0], exp.row));
         if (data[5:3] != exp.col)
            report($sformatf("rank %0d: col %0d, wanted %0d", exp.rank, data[5:3], exp.col));
         if (data[11:6] != exp.slot)
            report($sformatf("rank %0d: slot %0d, wanted %0d",
                             exp.rank, data[11:6], exp.slot));
         if (data[17:12] != exp.rank)
            report($sformatf("rank field %0d, wanted %0d", data[17:12], exp.rank));
         if (data[RSP_DATA_W-1:18] != '0)
            report($sformatf("rank %0d: padding bits %h not zero",
                             exp.rank, data[RSP_DATA_W-1:18]));
         if (tl !== exp.last)
            report($sformatf("rank %0d: tlast %b, wanted %b", exp.rank, tl, exp.last));
      endtask
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;    // [0] start_req, rest zero
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // row, col, slot_index, rank, zeros
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int tx_idle_pct = 19;
   int rx_idle_pct = 66;

   spiral_order_tracker tracker = new;

   clipped_spiral_grid_order_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Result side: check every word taken, then stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_cell(rsp_tdata, rsp_tlast);
      end
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Offer one start word, with random gaps in front of it.
   task send_start(logic start_flag);
      logic [REQ_DATA_W-1:0] word;
      word = {{(REQ_DATA_W-1){1'b0}}, start_flag};
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      tracker.note_start(word);
   endtask

   // Wait until every owed cell has arrived and the walker has surely stopped.
   task wait_idle();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.set_register(idx, value);
   endtask

   // Set up a new grid once the block has gone quiet.
   task set_grid(logic [3:0] rows, logic [3:0] cols, logic [3:0] crow, logic [3:0] ccol);
      wait_idle();
      csr_write(CSR_GRID_ROWS, rows);
      csr_write(CSR_GRID_COLS, cols);
      csr_write(CSR_CENTER_ROW, crow);
      csr_write(CSR_CENTER_COL, ccol);
      csr_valid <= 1'b0;
   endtask

   // Mostly legal sizes and centres, now and then anything the field holds.
   function logic [3:0] pick_size();
      return ($urandom_range(3) != 0) ? 4'($urandom_range(8, 1)) : 4'($urandom_range(15));
   endfunction

   function logic [3:0] pick_centre();
      return ($urandom_range(3) != 0) ? 4'($urandom_range(7)) : 4'($urandom_range(15));
   endfunction

   initial begin
      int starts;
      int batch;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed runs on the reset grid: a start word with the flag low,
      // then starts back to back, and another word with the flag low.
      send_start(1'b0);
      send_start(1'b1);
      send_start(1'b1);
      send_start(1'b0);
      // Single cell grid, zero sizes with the centre clamped, oversized sizes with
      // a corner centre, and 8 by 8 grids centred on the other three corners.
      set_grid(4'd1, 4'd1, 4'd0, 4'd0);
      send_start(1'b1);
      set_grid(4'd0, 4'd0, 4'd7, 4'd7);
      send_start(1'b1);
      set_grid(4'd15, 4'd15, 4'd0, 4'd0);
      send_start(1'b1);
      set_grid(4'd8, 4'd8, 4'd7, 4'd7);
      send_start(1'b1);
      set_grid(4'd8, 4'd8, 4'd0, 4'd7);
      send_start(1'b1);
      set_grid(4'd8, 4'd8, 4'd7, 4'd0);
      send_start(1'b1);
      // Thin grids, centre values with the top data bit set, and a row count
      // just above the limit.
      set_grid(4'd1, 4'd8, 4'd15, 4'd3);
      send_start(1'b1);
      set_grid(4'd8, 4'd1, 4'd2, 4'd12);
      send_start(1'b1);
      set_grid(4'd9, 4'd3, 4'd4, 4'd9);
      send_start(1'b1);
      send_start(1'b0);

      // Random runs in three stretches of handshake pressure; every start
      // word sent counts towards a stretch.
      for (int seg = 0; seg < 3; seg++) begin
         case (seg)
            0:       begin tx_idle_pct = 19; rx_idle_pct = 66; end
            1:       begin tx_idle_pct = 66; rx_idle_pct = 19; end
            default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
         endcase
         starts = 0;
         while (starts < 115) begin
            set_grid(pick_size(), pick_size(), pick_centre(), pick_centre());
            batch = $urandom_range(12, 3);
            for (int i = 0; i < batch; i++) begin
               if ($urandom_range(9) < 2) begin
                  send_start(1'b0);
               end else begin
                  send_start(1'b1);
               end
               starts++;
            end
         end
      end

      wait_idle();
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("clipped_spiral_grid_order_unit test passed");
      end else begin
         $display("clipped_spiral_grid_order_unit test failed");
      end
      $finish;
   end

   // Watchdog for a block that stops answering.
   initial begin
      #40_000_000;
      $display("clipped_spiral_grid_order_unit test failed");
      $finish;
   end

endmodule
